### design/qgpu_pkg.sv
// Shared constants and control types for the quality-guided phase unwrapper.
package qgpu_pkg;

    localparam int QGPU_MAX_PIXELS = 4096;
    localparam int QGPU_MAX_SIDE = 64;

    localparam int QGPU_CFG_W = 7;
    localparam int QGPU_CFG_INDEX_W = 2;
    localparam int QGPU_PHASE_W = 16;
    localparam int QGPU_QUAL_W = 16;
    localparam int QGPU_UNW_W = 32;
    localparam int QGPU_READ_INDEX_W = 12;
    localparam int QGPU_CFG_RESET = 64;

    localparam int QGPU_ENTRY_FIXED_W =
        QGPU_QUAL_W + QGPU_UNW_W + QGPU_PHASE_W + 2 * QGPU_CFG_W;

    localparam logic [QGPU_CFG_INDEX_W-1:0] CFG_COLUMN_LENGTH = 2'd0;
    localparam logic [QGPU_CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [1:0] MARK_CLEAR = 2'b00;
    localparam logic [1:0] MARK_INVALID = 2'b01;
    localparam logic [1:0] MARK_DONE = 2'b10;

    typedef struct packed {
        logic push;
        logic pop;
    } qgpu_heap_cmd_t;

    typedef struct packed {
        logic busy;
        logic empty;
    } qgpu_heap_status_t;

endpackage

### design/qgpu_heap.sv
// Binary max-heap of pixel entries keyed by quality, with push and pop sequencer.
module qgpu_heap
    import qgpu_pkg::*;
#(
    parameter int MAX_PIXELS = QGPU_MAX_PIXELS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qgpu_heap_cmd_t          cmd,
    input  logic [QGPU_ENTRY_FIXED_W+$clog2(MAX_PIXELS)-1:0] push_entry,
    output logic [QGPU_ENTRY_FIXED_W+$clog2(MAX_PIXELS)-1:0] pop_entry,
    output qgpu_heap_status_t       status
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = $clog2(MAX_PIXELS + 1);
    localparam int PW = SW + 1;
    localparam int EW = QGPU_ENTRY_FIXED_W + AW;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP,
        H_POP0,
        H_DN,
        H_FIN
    } heap_state_t;

    heap_state_t     state_reg;
    logic [EW-1:0]   heap_mem [MAX_PIXELS];
    logic [EW-1:0]   rd_a_reg;
    logic [EW-1:0]   rd_b_reg;
    logic [EW-1:0]   hold_reg;
    logic [EW-1:0]   top_reg;
    logic [SW-1:0]   count_reg;
    logic [AW-1:0]   pos_reg;
    logic [AW-1:0]   par_reg;
    logic [AW-1:0]   ch_reg;

    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [EW-1:0]   wdata;

    logic [SW-1:0]   count_dec;
    logic [AW-1:0]   push_par;
    logic [AW-1:0]   up_par;
    logic [PW-1:0]   n_ext;
    logic            use_b;
    logic [EW-1:0]   pick;
    logic [AW-1:0]   pick_idx;
    logic [PW-1:0]   c2;

    function automatic logic [QGPU_QUAL_W-1:0] key_of(input logic [EW-1:0] e);
        return e[EW-1 -: QGPU_QUAL_W];
    endfunction

    assign count_dec = SW'(count_reg - 1'b1);
    assign push_par = AW'(count_dec >> 1);
    assign up_par = AW'((par_reg - 1'b1) >> 1);
    assign n_ext = PW'(count_reg);
    assign use_b = (PW'(ch_reg) + PW'(1) < n_ext) && (key_of(rd_a_reg) < key_of(rd_b_reg));
    assign pick = use_b ? rd_b_reg : rd_a_reg;
    assign pick_idx = use_b ? AW'(ch_reg + 1'b1) : ch_reg;
    assign c2 = PW'({pick_idx, 1'b1});

    assign pop_entry = top_reg;
    assign status.busy = (state_reg != H_IDLE);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        we = 1'b0;
        waddr = pos_reg;
        wdata = hold_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.push)
                begin
                    if (count_reg == '0)
                    begin
                        we = 1'b1;
                        waddr = '0;
                        wdata = push_entry;
                    end
                    addr_a = push_par;
                end
                else if (cmd.pop)
                begin
                    addr_a = '0;
                    addr_b = AW'(count_dec);
                end
            end
            H_UP:
            begin
                we = 1'b1;
                if (key_of(rd_a_reg) < key_of(hold_reg))
                begin
                    wdata = rd_a_reg;
                    addr_a = up_par;
                end
            end
            H_POP0:
            begin
                addr_a = AW'(1);
                addr_b = AW'(2);
                if (count_reg == SW'(1))
                begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = rd_b_reg;
                end
            end
            H_DN:
            begin
                we = 1'b1;
                if (key_of(hold_reg) < key_of(pick))
                begin
                    wdata = pick;
                    addr_a = AW'(c2);
                    addr_b = AW'(c2 + PW'(1));
                end
            end
            H_FIN:
            begin
                we = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_reg <= heap_mem[addr_a];
        rd_b_reg <= heap_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                H_IDLE:
                begin
                    if (cmd.push)
                    begin
                        hold_reg <= push_entry;
                        pos_reg <= AW'(count_reg);
                        par_reg <= push_par;
                        count_reg <= SW'(count_reg + 1'b1);
                        if (count_reg != '0)
                        begin
                            state_reg <= H_UP;
                        end
                    end
                    else if (cmd.pop)
                    begin
                        count_reg <= count_dec;
                        state_reg <= H_POP0;
                    end
                end
                H_UP:
                begin
                    if (key_of(rd_a_reg) < key_of(hold_reg))
                    begin
                        pos_reg <= par_reg;
                        par_reg <= up_par;
                        state_reg <= (par_reg != '0) ? H_UP : H_FIN;
                    end
                    else
                    begin
                        state_reg <= H_IDLE;
                    end
                end
                H_POP0:
                begin
                    top_reg <= rd_a_reg;
                    hold_reg <= rd_b_reg;
                    pos_reg <= '0;
                    ch_reg <= AW'(1);
                    state_reg <= (count_reg > SW'(1)) ? H_DN : H_IDLE;
                end
                H_DN:
                begin
                    if (key_of(hold_reg) < key_of(pick))
                    begin
                        pos_reg <= pick_idx;
                        ch_reg <= AW'(c2);
                        state_reg <= (c2 < n_ext) ? H_DN : H_FIN;
                    end
                    else
                    begin
                        state_reg <= H_IDLE;
                    end
                end
                H_FIN:
                begin
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

endmodule

### design/quality_guided_phase_unwrap.sv
// Top level of the quality-guided phase unwrapper: grid stores, load, read and unwrap sequencer.
//
// A load (mode 0) leaves the block ready, so samples stream in one per cycle. The load that
// completes the grid starts the unwrap; busy then stays high while the heap sequencer runs,
// which moves one heap level per cycle. Per reached pixel this costs one pop, up to four
// neighbor checks (a neighbor off the grid skips the memory read) and one push per unreached
// neighbor. A read (mode 1) is registered through S_READ and its result appears on the
// result ports with done high for one cycle; the receiver cannot stall it. A configuration
// write keeps the block busy through S_CFG1 and S_CFG2 while the grid size settles. A
// configuration transaction is only taken while no input transaction is offered.
module quality_guided_phase_unwrap
    import qgpu_pkg::*;
#(
    parameter int MAX_PIXELS = QGPU_MAX_PIXELS,
    parameter int MAX_SIDE = QGPU_MAX_SIDE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic signed [QGPU_PHASE_W-1:0] phase_in,
    input  logic                          invalid_in,
    input  logic [QGPU_QUAL_W-1:0]        quality_in,
    input  logic [QGPU_READ_INDEX_W-1:0]  read_index,
    output logic                          done,
    output logic signed [QGPU_UNW_W-1:0]  unwrapped_phase,
    output logic                          unwrapped_ok,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [QGPU_CFG_INDEX_W-1:0]   cfg_index,
    input  logic [QGPU_CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = $clog2(MAX_PIXELS + 1);
    localparam int RW = (SW > QGPU_READ_INDEX_W) ? SW : QGPU_READ_INDEX_W;
    localparam int EW = QGPU_ENTRY_FIXED_W + AW;
    localparam int SIDE_LIM = (MAX_SIDE < MAX_PIXELS) ? MAX_SIDE : MAX_PIXELS;
    localparam int RST_LEN = (QGPU_CFG_RESET < SIDE_LIM) ? QGPU_CFG_RESET : SIDE_LIM;
    localparam int RST_CNT_SAT = RST_LEN;
    localparam int RST_CNT = (RST_CNT_SAT < MAX_PIXELS / RST_LEN) ?
        RST_CNT_SAT : MAX_PIXELS / RST_LEN;
    localparam int RST_SIZE = RST_LEN * RST_CNT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CFG1,
        S_CFG2,
        S_SEED,
        S_PUSHW,
        S_POP,
        S_POPW,
        S_NB,
        S_NBW
    } state_t;

    state_t                  state_reg;
    logic [QGPU_CFG_W-1:0]   len_raw_reg;
    logic [QGPU_CFG_W-1:0]   cnt_raw_reg;
    logic [QGPU_CFG_W-1:0]   eff_len_reg;
    logic [QGPU_CFG_W-1:0]   eff_cnt_reg;
    logic [SW-1:0]           size_reg;
    logic [SW-1:0]           load_count_reg;
    logic [QGPU_CFG_W-1:0]   ld_x_reg;
    logic [QGPU_CFG_W-1:0]   ld_y_reg;
    logic                    grid_ok_reg;
    logic                    seed_found_reg;
    logic [QGPU_QUAL_W-1:0]  seed_q_reg;
    logic [QGPU_PHASE_W-1:0] seed_ph_reg;
    logic [QGPU_CFG_W-1:0]   seed_x_reg;
    logic [QGPU_CFG_W-1:0]   seed_y_reg;
    logic [AW-1:0]           seed_pix_reg;
    logic                    rd_range_reg;
    logic [EW-1:0]           cur_reg;
    logic [1:0]              nb_sel_reg;
    logic [AW-1:0]           nb_pix_reg;
    logic [QGPU_CFG_W-1:0]   nb_x_reg;
    logic [QGPU_CFG_W-1:0]   nb_y_reg;
    logic                    done_reg;
    logic [QGPU_UNW_W-1:0]   unw_out_reg;
    logic                    ok_out_reg;

    logic [QGPU_PHASE_W-1:0] phase_mem [MAX_PIXELS];
    logic [QGPU_QUAL_W-1:0]  qual_mem [MAX_PIXELS];
    logic [1:0]              mark_mem [MAX_PIXELS];
    logic [QGPU_UNW_W-1:0]   unw_mem [MAX_PIXELS];
    logic [QGPU_PHASE_W-1:0] phase_rd_reg;
    logic [QGPU_QUAL_W-1:0]  qual_rd_reg;
    logic [1:0]              mark_rd_reg;
    logic [QGPU_UNW_W-1:0]   unw_rd_reg;

    logic                    accept;
    logic                    load_we;
    logic [AW-1:0]           load_addr;
    logic                    mark_we;
    logic [AW-1:0]           mark_wa;
    logic [1:0]              mark_wd;
    logic                    unw_we;
    logic [QGPU_UNW_W-1:0]   unw_wd;
    logic [AW-1:0]           mark_ra;

    logic [QGPU_UNW_W-1:0]   cur_unw;
    logic [QGPU_PHASE_W-1:0] cur_ph;
    logic [QGPU_CFG_W-1:0]   cur_x;
    logic [QGPU_CFG_W-1:0]   cur_y;
    logic [AW-1:0]           cur_pix;
    logic                    nb_ok;
    logic [AW-1:0]           nb_pix;
    logic [QGPU_CFG_W-1:0]   nb_x;
    logic [QGPU_CFG_W-1:0]   nb_y;
    logic [QGPU_PHASE_W-1:0] ph_diff;
    logic [QGPU_UNW_W-1:0]   nb_unw;
    logic [QGPU_UNW_W-1:0]   seed_unw;

    logic                    first_load;
    logic [QGPU_CFG_W-1:0]   x_now;
    logic [QGPU_CFG_W-1:0]   y_now;
    logic                    seed_take;
    logic [SW-1:0]           load_count_inc;
    logic [2*QGPU_CFG_W-1:0] prod;

    qgpu_heap_cmd_t          heap_cmd;
    qgpu_heap_status_t       heap_status;
    logic [EW-1:0]           push_entry;
    logic [EW-1:0]           pop_entry;

    function automatic logic [QGPU_CFG_W-1:0] sat_side(input logic [QGPU_CFG_W-1:0] v);
        logic [QGPU_CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = QGPU_CFG_W'(1);
        end
        else if (int'(v) > SIDE_LIM)
        begin
            r = QGPU_CFG_W'(SIDE_LIM);
        end
        return r;
    endfunction

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept = start && !busy;
    assign done = done_reg;
    assign unwrapped_phase = unw_out_reg;
    assign unwrapped_ok = ok_out_reg;

    assign cur_pix = cur_reg[AW-1:0];
    assign cur_y = cur_reg[AW+QGPU_CFG_W-1:AW];
    assign cur_x = cur_reg[AW+2*QGPU_CFG_W-1:AW+QGPU_CFG_W];
    assign cur_ph = cur_reg[AW+2*QGPU_CFG_W+QGPU_PHASE_W-1:AW+2*QGPU_CFG_W];
    assign cur_unw = cur_reg[EW-QGPU_QUAL_W-1:AW+2*QGPU_CFG_W+QGPU_PHASE_W];

    assign first_load = (load_count_reg == '0);
    assign x_now = first_load ? '0 : ld_x_reg;
    assign y_now = first_load ? '0 : ld_y_reg;
    assign seed_take = !invalid_in &&
        (first_load || !seed_found_reg || (quality_in > seed_q_reg));
    assign load_count_inc = SW'(load_count_reg + 1'b1);
    assign load_addr = AW'(load_count_reg);
    assign load_we = accept && !mode;
    assign prod = eff_len_reg * eff_cnt_reg;

    assign ph_diff = phase_rd_reg - cur_ph;
    assign nb_unw = cur_unw + {{(QGPU_UNW_W-QGPU_PHASE_W){ph_diff[QGPU_PHASE_W-1]}}, ph_diff};
    assign seed_unw = {{(QGPU_UNW_W-QGPU_PHASE_W){seed_ph_reg[QGPU_PHASE_W-1]}}, seed_ph_reg};

    always_comb
    begin
        nb_ok = 1'b0;
        nb_pix = cur_pix;
        nb_x = cur_x;
        nb_y = cur_y;
        case (nb_sel_reg)
            2'd0:
            begin
                nb_ok = (cur_x != '0);
                nb_pix = AW'(cur_pix - 1'b1);
                nb_x = QGPU_CFG_W'(cur_x - 1'b1);
            end
            2'd1:
            begin
                nb_ok = (QGPU_CFG_W'(cur_x + 1'b1) < eff_len_reg) && (cur_x != '1);
                nb_pix = AW'(cur_pix + 1'b1);
                nb_x = QGPU_CFG_W'(cur_x + 1'b1);
            end
            2'd2:
            begin
                nb_ok = (cur_y != '0);
                nb_pix = AW'(cur_pix - AW'(eff_len_reg));
                nb_y = QGPU_CFG_W'(cur_y - 1'b1);
            end
            default:
            begin
                nb_ok = (QGPU_CFG_W'(cur_y + 1'b1) < eff_cnt_reg) && (cur_y != '1);
                nb_pix = AW'(cur_pix + AW'(eff_len_reg));
                nb_y = QGPU_CFG_W'(cur_y + 1'b1);
            end
        endcase
    end

    always_comb
    begin
        mark_we = 1'b0;
        mark_wa = load_addr;
        mark_wd = invalid_in ? MARK_INVALID : MARK_CLEAR;
        unw_we = 1'b0;
        unw_wd = nb_unw;
        heap_cmd = '0;
        push_entry = {qual_rd_reg, nb_unw, phase_rd_reg, nb_x_reg, nb_y_reg, nb_pix_reg};
        mark_ra = (state_reg == S_NB) ? nb_pix : AW'(read_index);
        if (load_we)
        begin
            mark_we = 1'b1;
        end
        else if (state_reg == S_SEED && seed_found_reg)
        begin
            mark_we = 1'b1;
            mark_wa = seed_pix_reg;
            mark_wd = MARK_DONE;
            unw_we = 1'b1;
            unw_wd = seed_unw;
            heap_cmd.push = 1'b1;
            push_entry = {seed_q_reg, seed_unw, seed_ph_reg, seed_x_reg, seed_y_reg,
                seed_pix_reg};
        end
        else if (state_reg == S_NBW && mark_rd_reg == MARK_CLEAR)
        begin
            mark_we = 1'b1;
            mark_wa = nb_pix_reg;
            mark_wd = MARK_DONE;
            unw_we = 1'b1;
            heap_cmd.push = 1'b1;
        end
        else if (state_reg == S_POP && !heap_status.empty)
        begin
            heap_cmd.pop = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            phase_mem[load_addr] <= phase_in;
            qual_mem[load_addr] <= quality_in;
        end
        phase_rd_reg <= phase_mem[nb_pix];
        qual_rd_reg <= qual_mem[nb_pix];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[mark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (unw_we)
        begin
            unw_mem[mark_wa] <= unw_wd;
        end
        unw_rd_reg <= unw_mem[mark_ra];
    end

    qgpu_heap #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_heap (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (heap_cmd),
        .push_entry (push_entry),
        .pop_entry  (pop_entry),
        .status     (heap_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_raw_reg <= QGPU_CFG_W'(QGPU_CFG_RESET);
            cnt_raw_reg <= QGPU_CFG_W'(QGPU_CFG_RESET);
            eff_len_reg <= QGPU_CFG_W'(RST_LEN);
            eff_cnt_reg <= QGPU_CFG_W'(RST_CNT);
            size_reg <= SW'(RST_SIZE);
            load_count_reg <= '0;
            ld_x_reg <= '0;
            ld_y_reg <= '0;
            grid_ok_reg <= 1'b0;
            seed_found_reg <= 1'b0;
            nb_sel_reg <= '0;
            done_reg <= 1'b0;
            ok_out_reg <= 1'b0;
            unw_out_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready && (cfg_index == CFG_COLUMN_LENGTH ||
                        cfg_index == CFG_COLUMN_COUNT))
                    begin
                        if (cfg_index == CFG_COLUMN_LENGTH)
                        begin
                            len_raw_reg <= cfg_data;
                        end
                        else
                        begin
                            cnt_raw_reg <= cfg_data;
                        end
                        load_count_reg <= '0;
                        grid_ok_reg <= 1'b0;
                        seed_found_reg <= 1'b0;
                        state_reg <= S_CFG1;
                    end
                    else if (cfg_valid && cfg_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (accept && mode)
                    begin
                        rd_range_reg <= (RW'(read_index) < RW'(size_reg));
                        state_reg <= S_READ;
                    end
                    else if (accept)
                    begin
                        if (first_load)
                        begin
                            grid_ok_reg <= 1'b0;
                        end
                        if (seed_take)
                        begin
                            seed_found_reg <= 1'b1;
                            seed_q_reg <= quality_in;
                            seed_ph_reg <= phase_in;
                            seed_x_reg <= x_now;
                            seed_y_reg <= y_now;
                            seed_pix_reg <= load_addr;
                        end
                        else if (first_load)
                        begin
                            seed_found_reg <= 1'b0;
                        end
                        if (QGPU_CFG_W'(x_now + 1'b1) == eff_len_reg)
                        begin
                            ld_x_reg <= '0;
                            ld_y_reg <= QGPU_CFG_W'(y_now + 1'b1);
                        end
                        else
                        begin
                            ld_x_reg <= QGPU_CFG_W'(x_now + 1'b1);
                            ld_y_reg <= y_now;
                        end
                        if (load_count_inc >= size_reg)
                        begin
                            load_count_reg <= '0;
                            state_reg <= S_SEED;
                        end
                        else
                        begin
                            load_count_reg <= load_count_inc;
                        end
                    end
                end
                S_READ:
                begin
                    ok_out_reg <= grid_ok_reg && rd_range_reg && mark_rd_reg[1];
                    unw_out_reg <= (grid_ok_reg && rd_range_reg && mark_rd_reg[1]) ?
                        unw_rd_reg : '0;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_CFG1:
                begin
                    eff_len_reg <= sat_side(len_raw_reg);
                    eff_cnt_reg <= sat_side(cnt_raw_reg);
                    state_reg <= S_CFG2;
                end
                S_CFG2:
                begin
                    if (int'(prod) > MAX_PIXELS)
                    begin
                        eff_cnt_reg <= QGPU_CFG_W'(eff_cnt_reg - 1'b1);
                    end
                    else
                    begin
                        size_reg <= SW'(prod);
                        state_reg <= S_IDLE;
                    end
                end
                S_SEED:
                begin
                    grid_ok_reg <= 1'b1;
                    nb_sel_reg <= 2'd3;
                    state_reg <= seed_found_reg ? S_PUSHW : S_IDLE;
                end
                S_PUSHW:
                begin
                    if (!heap_status.busy)
                    begin
                        if (nb_sel_reg == 2'd3)
                        begin
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            nb_sel_reg <= nb_sel_reg + 2'd1;
                            state_reg <= S_NB;
                        end
                    end
                end
                S_POP:
                begin
                    state_reg <= heap_status.empty ? S_IDLE : S_POPW;
                end
                S_POPW:
                begin
                    if (!heap_status.busy)
                    begin
                        cur_reg <= pop_entry;
                        nb_sel_reg <= '0;
                        state_reg <= S_NB;
                    end
                end
                S_NB:
                begin
                    if (nb_ok)
                    begin
                        nb_pix_reg <= nb_pix;
                        nb_x_reg <= nb_x;
                        nb_y_reg <= nb_y;
                        state_reg <= S_NBW;
                    end
                    else if (nb_sel_reg == 2'd3)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        nb_sel_reg <= nb_sel_reg + 2'd1;
                    end
                end
                S_NBW:
                begin
                    if (mark_rd_reg == MARK_CLEAR)
                    begin
                        state_reg <= S_PUSHW;
                    end
                    else if (nb_sel_reg == 2'd3)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        nb_sel_reg <= nb_sel_reg + 2'd1;
                        state_reg <= S_NB;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
